@@ rtl/rcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants for the resistor color code encoder
// Digit widths, double-dabble geometry and the BCD word passed between the
// conversion pipeline and the band selection stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

    // Input and digit geometry
    localparam int RES_W      = 37;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 12;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W      = 4;

    // Double-dabble shift word: BCD digits above the remaining binary bits
    localparam int DD_W            = BCD_W + RES_W;
    localparam int STEPS_PER_STAGE = 8;
    localparam int NUM_DD_STAGES   = (RES_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Decimal constants
    localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;
    localparam logic [DIGIT_W-1:0] ROUND_HALF = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
    localparam logic [DIGIT_W-1:0] DD_ADJUST  = 4'd3;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

endpackage

`default_nettype wire

@@ rtl/rcc_bcd_pipe.sv @@
// ----------------------------------------------------------------------------
// rcc_bcd_pipe: pipelined binary to BCD conversion
// Runs the shift-and-add-3 conversion of the resistance, up to eight
// steps per register stage, with a valid bit and a local ready per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_bcd_pipe (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire logic [rcc_pkg::RES_W-1:0] resistance,
    output logic                           bcd_valid,
    input  wire logic                      bcd_ready,
    output rcc_pkg::bcd_t                  bcd
);

    import rcc_pkg::*;

    // One conversion step: add 3 to every digit of 5 or more, then shift left
    function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] w);
        logic [DD_W-1:0] a;
        a = w;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (a[RES_W + d*DIGIT_W +: DIGIT_W] >= ROUND_HALF)
            begin
                a[RES_W + d*DIGIT_W +: DIGIT_W] = a[RES_W + d*DIGIT_W +: DIGIT_W] + DD_ADJUST;
            end
        end
        return {a[DD_W-2:0], 1'b0};
    endfunction

    logic [DD_W-1:0] work_reg   [NUM_DD_STAGES];
    logic [DD_W-1:0] work_next  [NUM_DD_STAGES];
    logic            valid_reg  [NUM_DD_STAGES];
    logic            stage_ready[NUM_DD_STAGES];

    genvar s;
    generate
        for (s = 0; s < NUM_DD_STAGES; s++)
        begin : g_stage
            logic [DD_W-1:0] stage_in;
            logic            prev_valid;
            logic            next_ready;

            // Pick up the word from the input port or the previous stage
            if (s == 0)
            begin : g_first
                assign stage_in   = {{BCD_W{1'b0}}, resistance};
                assign prev_valid = item_valid;
            end
            else
            begin : g_inner
                assign stage_in   = work_reg[s-1];
                assign prev_valid = valid_reg[s-1];
            end

            if (s == NUM_DD_STAGES - 1)
            begin : g_last
                assign next_ready = bcd_ready;
            end
            else
            begin : g_mid
                assign next_ready = stage_ready[s+1];
            end

            // Advance when empty or when the word ahead moves on
            assign stage_ready[s] = !valid_reg[s] || next_ready;

            // Run this stage's share of the conversion steps
            always_comb
            begin
                work_next[s] = stage_in;
                for (int k = 0; k < STEPS_PER_STAGE; k++)
                begin
                    if (s * STEPS_PER_STAGE + k < RES_W)
                    begin
                        work_next[s] = dd_step(work_next[s]);
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (stage_ready[s])
                begin
                    valid_reg[s] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[s] && prev_valid)
                begin
                    work_reg[s] <= work_next[s];
                end
            end
        end
    endgenerate

    assign item_ready = stage_ready[0];
    assign bcd_valid  = valid_reg[NUM_DD_STAGES-1];
    assign bcd        = work_reg[NUM_DD_STAGES-1][DD_W-1 -: BCD_W];

endmodule

`default_nettype wire

@@ rtl/resistor_color_code_encoder.sv @@
// ----------------------------------------------------------------------------
// resistor_color_code_encoder: three-band resistor color code
// Converts a resistance in ohms into first digit, second digit and a
// power-of-ten multiplier, rounding half up on the third digit and
// saturating to 9,9,9 with an overrange flag when the value is too large.
//
//   channel  | direction | handshake                   | word
//   ---------+-----------+-----------------------------+-----------------------
//   item     | in        | item_valid / item_ready     | resistance[36:0]
//   result   | out       | result_valid / result_ready | first_digit,
//            |           |                             | second_digit,
//            |           |                             | multiplier, overrange
//
// One word enters per cycle while item_ready is high; a word passes through
// five binary to BCD stages of up to eight shift steps each (37 steps in
// all), one leading-digit select stage and one round and saturate stage.
// Reset clears only the valid bits; the data registers load on acceptance.
// Every stage has its own ready, so bubbles close up and a stalled result
// holds in the output register while earlier stages keep filling.
// ----------------------------------------------------------------------------
`default_nettype none

module resistor_color_code_encoder #(
    parameter int MAX_DIGITS = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire logic [rcc_pkg::RES_W-1:0] resistance,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output rcc_pkg::digit_t                first_digit,
    output rcc_pkg::digit_t                second_digit,
    output rcc_pkg::digit_t                multiplier,
    output logic                           overrange
);

    import rcc_pkg::*;

    typedef struct packed {
        digit_t d1;
        digit_t d2;
        digit_t d3;
        digit_t pw;
        logic   too_many;
    } lead_t;

    logic   bcd_valid;
    logic   bcd_ready;
    bcd_t   bcd;

    logic   lead_valid_reg;
    lead_t  lead_reg;
    lead_t  lead_next;
    logic   lead_ready;

    logic   result_valid_reg;
    logic   result_load;
    digit_t first_digit_reg;
    digit_t second_digit_reg;
    digit_t multiplier_reg;
    logic   overrange_reg;
    digit_t first_digit_next;
    digit_t second_digit_next;
    digit_t multiplier_next;
    logic   overrange_next;

    // Binary to BCD conversion
    rcc_bcd_pipe u_bcd_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .resistance (resistance),
        .bcd_valid  (bcd_valid),
        .bcd_ready  (bcd_ready),
        .bcd        (bcd)
    );

    // Locate the leading nonzero digit and take the top three digits
    always_comb
    begin
        logic [IDX_W-1:0] lead;
        lead = '0;
        for (int d = 1; d < NUM_DIGITS; d++)
        begin
            if (bcd[d] != '0)
            begin
                lead = IDX_W'(d);
            end
        end

        if (lead <= IDX_W'(1))
        begin
            lead_next.d1 = bcd[1];
            lead_next.d2 = bcd[0];
            lead_next.d3 = '0;
            lead_next.pw = '0;
        end
        else
        begin
            lead_next.d1 = bcd[lead];
            lead_next.d2 = bcd[lead - IDX_W'(1)];
            lead_next.d3 = bcd[lead - IDX_W'(2)];
            lead_next.pw = DIGIT_W'(lead - IDX_W'(1));
        end
        lead_next.too_many = (lead >= IDX_W'(MAX_DIGITS));
    end

    assign lead_ready = !lead_valid_reg || result_load;
    assign bcd_ready  = lead_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_valid_reg <= 1'b0;
        end
        else if (lead_ready)
        begin
            lead_valid_reg <= bcd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lead_ready && bcd_valid)
        begin
            lead_reg <= lead_next;
        end
    end

    // Round half up on the third digit, carry, then saturate
    always_comb
    begin
        digit_t d1;
        digit_t d2;
        digit_t pw;
        d1 = lead_reg.d1;
        d2 = lead_reg.d2;
        pw = lead_reg.pw;
        if (lead_reg.d3 >= ROUND_HALF)
        begin
            d2 = d2 + DIGIT_W'(1);
        end
        if (d2 == DEC_BASE)
        begin
            d2 = '0;
            d1 = d1 + DIGIT_W'(1);
            if (d1 == DEC_BASE)
            begin
                d1 = DIGIT_W'(1);
                pw = pw + DIGIT_W'(1);
            end
        end

        if (lead_reg.too_many || (pw > DIGIT_MAX))
        begin
            first_digit_next  = DIGIT_MAX;
            second_digit_next = DIGIT_MAX;
            multiplier_next   = DIGIT_MAX;
            overrange_next    = 1'b1;
        end
        else
        begin
            first_digit_next  = d1;
            second_digit_next = d2;
            multiplier_next   = pw;
            overrange_next    = 1'b0;
        end
    end

    // Output register: load when empty or when the held word is taken
    assign result_load = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= lead_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load && lead_valid_reg)
        begin
            first_digit_reg  <= first_digit_next;
            second_digit_reg <= second_digit_next;
            multiplier_reg   <= multiplier_next;
            overrange_reg    <= overrange_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign first_digit  = first_digit_reg;
    assign second_digit = second_digit_reg;
    assign multiplier   = multiplier_reg;
    assign overrange    = overrange_reg;

`ifndef SYNTHESIS
    // Saturated results always read 9,9,9
    a_over_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overrange) |->
            (first_digit == DIGIT_MAX && second_digit == DIGIT_MAX
             && multiplier == DIGIT_MAX))
        else $error("overrange result not saturated");

    // Every band is a decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (first_digit <= DIGIT_MAX && second_digit <= DIGIT_MAX
             && multiplier <= DIGIT_MAX))
        else $error("band outside 0 to 9");

    // A scaled value has a nonzero first digit
    a_lead_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !overrange && multiplier != '0) |-> (first_digit != '0))
        else $error("scaled result with zero first digit");

    // A stalled select stage holds its word
    a_lead_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (lead_valid_reg && !lead_ready) |=> (lead_valid_reg && $stable(lead_reg)))
        else $error("select stage lost a stalled word");
`endif

endmodule

`default_nettype wire
